@@ rtl/hrhc_pkg.sv @@
// Package for the HTTP request header checker: state record, phase and URL
// mode encodings, verdict codes, character constants and token tables.
// No dependencies.
`timescale 1ns / 1ps

package hrhc_pkg;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChH     = 8'h68;

  localparam int unsigned GetLen = 3;
  localparam int unsigned VerLen = 8;
  localparam int unsigned PfxLen = 7;

  // Lowercase token tables, first character at index 0
  localparam logic [7:0] TokGet [GetLen] = '{8'h67, 8'h65, 8'h74};
  localparam logic [7:0] TokVer [VerLen] =
    '{8'h68, 8'h74, 8'h74, 8'h70, 8'h2f, 8'h31, 8'h2e, 8'h31};
  localparam logic [7:0] TokPfx [PfxLen] =
    '{8'h68, 8'h74, 8'h74, 8'h70, 8'h3a, 8'h2f, 8'h2f};

  typedef enum logic [1:0] {
    VERDICT_PENDING  = 2'd0,
    VERDICT_COMPLETE = 2'd1,
    VERDICT_BAD      = 2'd2
  } verdict_e;

  // Request line phase, one-hot
  typedef enum logic [4:0] {
    PH_METHOD  = 5'b00001,
    PH_GAP1    = 5'b00010,
    PH_URL     = 5'b00100,
    PH_GAP2    = 5'b01000,
    PH_VERSION = 5'b10000
  } phase_e;

  // URL progress, one-hot
  typedef enum logic [3:0] {
    URL_NONE   = 4'b0001,
    URL_SLASH  = 4'b0010,
    URL_PREFIX = 4'b0100,
    URL_HOST   = 4'b1000
  } url_mode_e;

  typedef struct packed {
    logic      in_headers;
    logic      saw_cr;
    phase_e    line_phase;
    logic [3:0] match_pos;
    url_mode_e url_mode;
    logic      line_empty;
    logic      line_failed;
  } state_t;

  localparam state_t StateReset = '{
    in_headers:  1'b0,
    saw_cr:      1'b0,
    line_phase:  PH_METHOD,
    match_pos:   4'd0,
    url_mode:    URL_NONE,
    line_empty:  1'b1,
    line_failed: 1'b0
  };

  typedef struct packed {
    verdict_e verdict;
    logic     line_done;
  } result_t;

  function automatic logic [7:0] to_lower(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

endpackage

@@ rtl/http_request_header_checker.sv @@
// Top level of the HTTP/1.1 GET request checker: parser state register,
// per-byte step logic and the output buffer. Depends on hrhc_pkg,
// hrhc_step and hrhc_obuf.
// Each accepted byte's result word is registered in the output buffer.
// Throughput: one byte per cycle; the parser state register updates in the
// accept cycle, and the skid stage keeps tready high for one stalled word.
// Reset: asynchronous, active low; clears the parser to the start of a
// request and empties the output buffer.
`timescale 1ns / 1ps

module http_request_header_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [1:0] verdict, [7:2] zero
  output logic       m_axis_tlast    // line_done
);

  hrhc_pkg::state_t  state_q;
  hrhc_pkg::state_t  state_d;
  hrhc_pkg::result_t step_res;
  hrhc_pkg::result_t out_res;
  logic              in_ready;
  logic              in_fire;

  assign s_axis_tready = in_ready;
  assign in_fire       = s_axis_tvalid && in_ready;

  hrhc_step u_step (
    .state_i  (state_q),
    .byte_i   (s_axis_tdata),
    .state_o  (state_d),
    .result_o (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hrhc_pkg::StateReset;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  hrhc_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (in_ready),
    .in_data_i   (step_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.verdict};
  assign m_axis_tlast = out_res.line_done;

endmodule

@@ rtl/hrhc_step.sv @@
// Next-state and result logic for one request byte.
// Depends on hrhc_pkg.
`timescale 1ns / 1ps

module hrhc_step (
  input  hrhc_pkg::state_t  state_i,
  input  logic [7:0]        byte_i,
  output hrhc_pkg::state_t  state_o,
  output hrhc_pkg::result_t result_o
);

  // One URL character; caller guarantees line_failed is clear
  function automatic hrhc_pkg::state_t url_char(hrhc_pkg::state_t s, logic [7:0] c);
    hrhc_pkg::state_t r;
    logic [7:0] l;
    r = s;
    l = hrhc_pkg::to_lower(c);
    case (s.url_mode)
      hrhc_pkg::URL_NONE: begin
        if (c == hrhc_pkg::ChSlash) begin
          r.url_mode = hrhc_pkg::URL_SLASH;
        end else if (l == hrhc_pkg::ChH) begin
          r.url_mode  = hrhc_pkg::URL_PREFIX;
          r.match_pos = 4'd1;
        end else begin
          r.line_failed = 1'b1;
        end
      end
      hrhc_pkg::URL_PREFIX: begin
        if (s.match_pos < 4'(hrhc_pkg::PfxLen)) begin
          if (l == hrhc_pkg::TokPfx[s.match_pos[2:0]]) begin
            r.match_pos = s.match_pos + 4'd1;
          end else begin
            r.line_failed = 1'b1;
          end
        end else if (c == hrhc_pkg::ChSlash) begin
          r.url_mode = hrhc_pkg::URL_HOST;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  hrhc_pkg::state_t rq;
  logic [7:0]       lc;
  logic             ws;
  logic             line_ok;

  assign lc      = hrhc_pkg::to_lower(byte_i);
  assign ws      = hrhc_pkg::is_ws(byte_i);
  assign line_ok = !state_i.line_failed && (state_i.line_phase == hrhc_pkg::PH_VERSION)
                   && (state_i.match_pos == 4'(hrhc_pkg::VerLen));

  // Request line checking for one content byte
  always_comb begin
    rq = state_i;
    rq.line_empty = 1'b0;
    if (!state_i.in_headers && !state_i.line_failed) begin
      unique case (state_i.line_phase)
        hrhc_pkg::PH_METHOD: begin
          if (ws) begin
            if (state_i.match_pos == 4'(hrhc_pkg::GetLen)) begin
              rq.line_phase = hrhc_pkg::PH_GAP1;
            end else begin
              rq.line_failed = 1'b1;
            end
          end else if (state_i.match_pos < 4'(hrhc_pkg::GetLen) &&
                       lc == hrhc_pkg::TokGet[state_i.match_pos[1:0]]) begin
            rq.match_pos = state_i.match_pos + 4'd1;
          end else begin
            rq.line_failed = 1'b1;
          end
        end
        hrhc_pkg::PH_GAP1: begin
          if (!ws) begin
            rq.line_phase = hrhc_pkg::PH_URL;
            rq.match_pos  = 4'd0;
            rq = url_char(rq, byte_i);
          end
        end
        hrhc_pkg::PH_URL: begin
          if (ws) begin
            if (state_i.url_mode == hrhc_pkg::URL_SLASH ||
                state_i.url_mode == hrhc_pkg::URL_HOST) begin
              rq.line_phase = hrhc_pkg::PH_GAP2;
            end else begin
              rq.line_failed = 1'b1;
            end
          end else begin
            rq = url_char(rq, byte_i);
          end
        end
        hrhc_pkg::PH_GAP2: begin
          if (!ws) begin
            rq.line_phase = hrhc_pkg::PH_VERSION;
            if (lc == hrhc_pkg::TokVer[0]) begin
              rq.match_pos = 4'd1;
            end else begin
              rq.match_pos   = 4'd0;
              rq.line_failed = 1'b1;
            end
          end
        end
        hrhc_pkg::PH_VERSION: begin
          if (state_i.match_pos < 4'(hrhc_pkg::VerLen) &&
              lc == hrhc_pkg::TokVer[state_i.match_pos[2:0]]) begin
            rq.match_pos = state_i.match_pos + 4'd1;
          end else begin
            rq.line_failed = 1'b1;
          end
        end
        default: rq.line_failed = 1'b1;
      endcase
    end
  end

  always_comb begin
    state_o            = state_i;
    result_o.verdict   = hrhc_pkg::VERDICT_PENDING;
    result_o.line_done = 1'b0;
    if (state_i.saw_cr) begin
      if (byte_i == hrhc_pkg::ChLf) begin
        result_o.line_done = 1'b1;
        if (!state_i.in_headers && !line_ok) begin
          result_o.verdict = hrhc_pkg::VERDICT_BAD;
          state_o          = hrhc_pkg::StateReset;
        end else if (state_i.in_headers && state_i.line_empty) begin
          result_o.verdict = hrhc_pkg::VERDICT_COMPLETE;
          state_o          = hrhc_pkg::StateReset;
        end else begin
          // next line, header section
          state_o            = hrhc_pkg::StateReset;
          state_o.in_headers = 1'b1;
        end
      end else begin
        result_o.verdict = hrhc_pkg::VERDICT_BAD;
        state_o          = hrhc_pkg::StateReset;
      end
    end else if (byte_i == hrhc_pkg::ChCr) begin
      state_o.saw_cr = 1'b1;
    end else if (byte_i == hrhc_pkg::ChLf) begin
      result_o.verdict = hrhc_pkg::VERDICT_BAD;
      state_o          = hrhc_pkg::StateReset;
    end else begin
      state_o = rq;
    end
  end

endmodule

@@ rtl/hrhc_obuf.sv @@
// Result register with skid stage for the master-side stream.
// Depends on hrhc_pkg.
`timescale 1ns / 1ps

module hrhc_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hrhc_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hrhc_pkg::result_t out_data_o
);

  logic              out_valid_q;
  logic              skid_valid_q;
  hrhc_pkg::result_t out_data_q;
  hrhc_pkg::result_t skid_data_q;
  logic              in_fire;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_data_q <= skid_valid_q ? skid_data_q : in_data_i;
    end else if (in_fire) begin
      skid_data_q <= in_data_i;
    end
  end

endmodule
